[rtl/uf2bf_pkg.sv]
// ----------------------------------------------------------------------------
// UF2 block framer package
// Shared constants, register map, state and command types, and the CRC step.
// ----------------------------------------------------------------------------
`default_nettype none

package uf2bf_pkg;

  localparam int unsigned BLOCK_BYTES = 256;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int unsigned APB_ADDR_W  = 4;

  localparam logic [31:0] CRC_POLY        = 32'h04c11db7;
  localparam logic [31:0] CRC_INIT        = 32'hffffffff;
  localparam logic [31:0] MAGIC_START0    = 32'h0a324655;
  localparam logic [31:0] MAGIC_START1    = 32'h9e5d5157;
  localparam logic [31:0] HDR_FLAGS       = 32'h00002000;
  localparam logic [31:0] TRAILER_MAGIC   = 32'h0ab16f30;
  localparam logic [31:0] BLOCK_SIZE_WORD = 32'(BLOCK_BYTES);

  localparam logic [7:0] CRC_SPAN    = 8'd252;
  localparam logic [7:0] PAD_BYTE    = 8'hff;
  localparam logic [7:0] OFFSET_LAST = 8'(BLOCK_BYTES - 1);

  localparam logic [5:0] TAIL_ZEROS = 6'd55;
  localparam logic [5:0] MAX_RUN    = 6'd63;
  localparam logic [3:0] MAX_RES    = 4'd13;

  localparam logic [15:0] TOTAL_RESET  = 16'd1;
  localparam logic [31:0] BASE_RESET   = 32'h10000000;
  localparam logic [31:0] FAMILY_RESET = 32'he48bff56;
  localparam logic        CRC_EN_RESET = 1'b1;

  typedef enum logic [1:0] {
    REG_TOTAL_BLOCKS,
    REG_BASE_ADDRESS,
    REG_FAMILY_ID,
    REG_CRC_FIRST
  } uf2bf_reg_e;

  typedef enum logic [2:0] {
    HDR_MAGIC0,
    HDR_MAGIC1,
    HDR_FLAG_WORD,
    HDR_ADDRESS,
    HDR_SIZE,
    HDR_INDEX,
    HDR_TOTAL,
    HDR_FAMILY
  } uf2bf_hdr_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_BYTE,
    ST_TAIL
  } uf2bf_state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_HDR,
    OP_BYTE,
    OP_TAIL
  } uf2bf_op_e;

  typedef struct packed {
    uf2bf_op_e op;
    logic      go;
    logic      load;
    logic      flush;
  } uf2bf_cmd_t;

  typedef struct packed {
    logic offset_zero;
    logic offset_end;
    logic emit;
    logic last;
    logic hdr_done;
    logic tail_done;
  } uf2bf_stat_t;

  typedef struct packed {
    logic [15:0] total_blocks;
    logic [31:0] base_address;
    logic [31:0] family_id;
    logic        crc_first_block;
  } uf2bf_cfg_t;

  // One byte of an MSB-first CRC-32, data entering at the top bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic [7:0]  v;
    logic        top;
    c = crc;
    v = b;
    for (int i = 0; i < 8; i++) begin
      top = c[31] ^ v[7];
      c   = {c[30:0], 1'b0} ^ (top ? CRC_POLY : 32'h0);
      v   = {v[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/uf2bf_if.sv]
// ----------------------------------------------------------------------------
// UF2 block framer channel interfaces
// Byte input channel and word output channel with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface uf2bf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_image;

  modport source (output valid, output data_byte, output end_of_image, input ready);
  modport sink (input valid, input data_byte, input end_of_image, output ready);
endinterface

interface uf2bf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [5:0]  repeat_res;
  logic        run_last;

  modport source (output valid, output word, output repeat_res, output run_last, input ready);
  modport sink (input valid, input word, input repeat_res, input run_last, output ready);
endinterface

`default_nettype wire

[rtl/uf2_block_framer.sv]
// ----------------------------------------------------------------------------
// UF2 block framer
// Turns a firmware image, one byte per input word, into UF2 file words.
// ----------------------------------------------------------------------------
// The image enters on byte_in, one byte per word, end_of_image set on the
// final byte. Results leave on word_out as 32-bit file words, each with a
// repeat count; run_last marks the last result caused by one input byte.
// Bytes are taken one at a time. An ordinary byte is first accepted and then
// passes the packing and CRC step. The first byte of a block adds the header
// words, and the byte that fills a block adds the zero trailer and end magic.
// A final byte also adds pad bytes up to the end of the block. Every file
// word passes the run merger at one word per cycle unless the output is
// stalled; a result is registered onto word_out when its run closes, and the
// last run of a byte closes in the idle state that follows its last word,
// once the output register is free.
// If the receiver stalls, the held result stays on word_out and the merger
// and sequencer wait; no input is taken until the previous byte's results
// have been handed to the output register.
// Reset clears the block position, returns the CRC to all ones, loads the
// register defaults and leaves word_out empty. The user writes configuration
// over APB only while no byte is in progress; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module uf2_block_framer import uf2bf_pkg::*; #(
  parameter int unsigned BLOCK_INDEX_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  uf2bf_in_if.sink              byte_in,
  uf2bf_out_if.source           word_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  uf2bf_cfg_t  cfg;
  uf2bf_cmd_t  cmd;
  uf2bf_stat_t stat;
  logic        in_ready;
  logic        push_valid;
  logic [31:0] push_word;
  logic        push_ready;
  logic        flush_ok;

  assign byte_in.ready = in_ready;

  uf2bf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  uf2bf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_in.valid),
    .in_ready_o   (in_ready),
    .stat_i       (stat),
    .push_ready_i (push_ready),
    .flush_ok_i   (flush_ok),
    .cmd_o        (cmd)
  );

  uf2bf_datapath #(
    .BLOCK_INDEX_BITS (BLOCK_INDEX_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .data_byte_i    (byte_in.data_byte),
    .end_of_image_i (byte_in.end_of_image),
    .stat_o         (stat),
    .push_valid_o   (push_valid),
    .push_word_o    (push_word)
  );

  uf2bf_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_word_i  (push_word),
    .push_ready_o (push_ready),
    .flush_i      (cmd.flush),
    .flush_ok_o   (flush_ok),
    .out_valid_o  (word_out.valid),
    .out_ready_i  (word_out.ready),
    .out_word_o   (word_out.word),
    .out_rep_o    (word_out.repeat_res),
    .out_last_o   (word_out.run_last)
  );

endmodule

`default_nettype wire

[rtl/uf2bf_regs.sv]
// ----------------------------------------------------------------------------
// UF2 block framer configuration registers
// APB register file holding the header fields and the CRC enable.
// ----------------------------------------------------------------------------
`default_nettype none

module uf2bf_regs import uf2bf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output uf2bf_cfg_t            cfg_o
);

  uf2bf_cfg_t cfg_q, cfg_d;
  uf2bf_reg_e reg_sel;
  logic       wr_en;

  assign reg_sel = uf2bf_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_TOTAL_BLOCKS: cfg_d.total_blocks    = pwdata[15:0];
        REG_BASE_ADDRESS: cfg_d.base_address    = pwdata;
        REG_FAMILY_ID:    cfg_d.family_id       = pwdata;
        REG_CRC_FIRST:    cfg_d.crc_first_block = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TOTAL_BLOCKS: prdata = {16'h0, cfg_q.total_blocks};
      REG_BASE_ADDRESS: prdata = cfg_q.base_address;
      REG_FAMILY_ID:    prdata = cfg_q.family_id;
      REG_CRC_FIRST:    prdata = {31'h0, cfg_q.crc_first_block};
      default:          prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_blocks    <= TOTAL_RESET;
      cfg_q.base_address    <= BASE_RESET;
      cfg_q.family_id       <= FAMILY_RESET;
      cfg_q.crc_first_block <= CRC_EN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[rtl/uf2bf_ctrl.sv]
// ----------------------------------------------------------------------------
// UF2 block framer controller
// Sequences header, byte, padding and trailer work for each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module uf2bf_ctrl import uf2bf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  uf2bf_stat_t stat_i,
  input  logic        push_ready_i,
  input  logic        flush_ok_i,
  output uf2bf_cmd_t  cmd_o
);

  uf2bf_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && flush_ok_i) begin
          state_d = stat_i.offset_zero ? ST_HDR : ST_BYTE;
        end
      end
      ST_HDR: begin
        if (push_ready_i && stat_i.hdr_done) begin
          state_d = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (!stat_i.emit || push_ready_i) begin
          if (stat_i.offset_end) begin
            state_d = ST_TAIL;
          end else if (!stat_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (push_ready_i && stat_i.tail_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '{op: OP_NONE, go: 1'b0, load: 1'b0, flush: 1'b0};
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.flush = 1'b1;
        in_ready_o  = flush_ok_i;
        cmd_o.load  = in_valid_i && flush_ok_i;
      end
      ST_HDR: begin
        cmd_o.op = OP_HDR;
        cmd_o.go = push_ready_i;
      end
      ST_BYTE: begin
        cmd_o.op = OP_BYTE;
        cmd_o.go = !stat_i.emit || push_ready_i;
      end
      ST_TAIL: begin
        cmd_o.op = OP_TAIL;
        cmd_o.go = push_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/uf2bf_datapath.sv]
// ----------------------------------------------------------------------------
// UF2 block framer datapath
// Block position, word packing, CRC register and the word source selection.
// ----------------------------------------------------------------------------
`default_nettype none

module uf2bf_datapath import uf2bf_pkg::*; #(
  parameter int unsigned BLOCK_INDEX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  uf2bf_cmd_t  cmd_i,
  input  uf2bf_cfg_t  cfg_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_image_i,
  output uf2bf_stat_t stat_o,
  output logic        push_valid_o,
  output logic [31:0] push_word_o
);

  logic [7:0]                  byte_q, byte_d;
  logic                        last_q, last_d;
  logic [7:0]                  offset_q, offset_d;
  logic [BLOCK_INDEX_BITS-1:0] block_q, block_d;
  logic [23:0]                 asm_q, asm_d;
  logic [31:0]                 crc_q, crc_d;
  logic [5:0]                  cnt_q, cnt_d;

  logic        crc_on;
  logic        in_slot;
  logic        emit;
  logic        hdr_done;
  logic        tail_done;
  uf2bf_hdr_e  hdr_sel;
  logic [63:0] block_shift;
  logic [31:0] hdr_word;
  logic [31:0] tail_word;
  logic [31:0] byte_word;

  assign crc_on    = (block_q == '0) && cfg_i.crc_first_block;
  assign in_slot   = crc_on && (offset_q >= CRC_SPAN);
  assign emit      = in_slot ? (offset_q == OFFSET_LAST) : (offset_q[1:0] == 2'b11);
  assign hdr_sel   = uf2bf_hdr_e'(cnt_q[2:0]);
  assign hdr_done  = (hdr_sel == HDR_FAMILY);
  assign tail_done = (cnt_q == TAIL_ZEROS);

  assign block_shift = 64'(block_q) << BLOCK_SHIFT;

  always_comb begin
    unique case (hdr_sel)
      HDR_MAGIC0:    hdr_word = MAGIC_START0;
      HDR_MAGIC1:    hdr_word = MAGIC_START1;
      HDR_FLAG_WORD: hdr_word = HDR_FLAGS;
      HDR_ADDRESS:   hdr_word = cfg_i.base_address + block_shift[31:0];
      HDR_SIZE:      hdr_word = BLOCK_SIZE_WORD;
      HDR_INDEX:     hdr_word = 32'(block_q);
      HDR_TOTAL:     hdr_word = {16'h0, cfg_i.total_blocks};
      HDR_FAMILY:    hdr_word = cfg_i.family_id;
      default:       hdr_word = 32'h0;
    endcase
  end

  assign tail_word = tail_done ? TRAILER_MAGIC : 32'h0;
  assign byte_word = in_slot ? crc_q : {byte_q, asm_q};

  always_comb begin
    unique case (cmd_i.op)
      OP_HDR:  push_word_o = hdr_word;
      OP_BYTE: push_word_o = byte_word;
      OP_TAIL: push_word_o = tail_word;
      default: push_word_o = 32'h0;
    endcase
  end

  assign push_valid_o = cmd_i.go && ((cmd_i.op == OP_HDR) || (cmd_i.op == OP_TAIL) ||
                                     ((cmd_i.op == OP_BYTE) && emit));

  assign stat_o = '{offset_zero: (offset_q == 8'h0),
                    offset_end:  (offset_q == OFFSET_LAST),
                    emit:        emit,
                    last:        last_q,
                    hdr_done:    hdr_done,
                    tail_done:   tail_done};

  always_comb begin
    byte_d   = byte_q;
    last_d   = last_q;
    offset_d = offset_q;
    block_d  = block_q;
    asm_d    = asm_q;
    crc_d    = crc_q;
    cnt_d    = cnt_q;
    if (cmd_i.load) begin
      byte_d = data_byte_i;
      last_d = end_of_image_i;
    end
    if (cmd_i.go) begin
      unique case (cmd_i.op)
        OP_HDR: begin
          cnt_d = hdr_done ? 6'h0 : cnt_q + 6'd1;
        end
        OP_BYTE: begin
          if (!in_slot) begin
            if (crc_on) begin
              crc_d = crc_byte(crc_q, byte_q);
            end
            if (offset_q[1:0] == 2'b11) begin
              asm_d = 24'h0;
            end else begin
              asm_d = asm_q | (24'(byte_q) << {offset_q[1:0], 3'b000});
            end
          end
          offset_d = offset_q + 8'd1;
          byte_d   = PAD_BYTE;
        end
        OP_TAIL: begin
          if (tail_done) begin
            cnt_d    = 6'h0;
            offset_d = 8'h0;
            asm_d    = 24'h0;
            if (last_q) begin
              block_d = '0;
              crc_d   = CRC_INIT;
            end else begin
              block_d = block_q + BLOCK_INDEX_BITS'(1);
            end
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b0;
      offset_q <= 8'h0;
      block_q  <= '0;
      asm_q    <= 24'h0;
      crc_q    <= CRC_INIT;
      cnt_q    <= 6'h0;
    end else begin
      last_q   <= last_d;
      offset_q <= offset_d;
      block_q  <= block_d;
      asm_q    <= asm_d;
      crc_q    <= crc_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/uf2bf_merge.sv]
// ----------------------------------------------------------------------------
// UF2 block framer run merger
// Folds equal consecutive words into counted runs and holds the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module uf2bf_merge import uf2bf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  input  logic [31:0] push_word_i,
  output logic        push_ready_o,
  input  logic        flush_i,
  output logic        flush_ok_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_word_o,
  output logic [5:0]  out_rep_o,
  output logic        out_last_o
);

  logic        run_valid_q, run_valid_d;
  logic [31:0] run_word_q, run_word_d;
  logic [5:0]  run_cnt_q, run_cnt_d;
  logic [3:0]  res_cnt_q, res_cnt_d;
  logic        drop_q, drop_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic [5:0]  out_rep_q, out_rep_d;
  logic        out_last_q, out_last_d;

  logic out_free;
  logic match;
  logic final_res;

  assign out_free  = !out_valid_q || out_ready_i;
  assign match     = run_valid_q && (push_word_i == run_word_q) && (run_cnt_q != MAX_RUN);
  assign final_res = (res_cnt_q == MAX_RES - 4'd1);

  assign push_ready_o = drop_q || !run_valid_q || match || out_free;
  assign flush_ok_o   = !run_valid_q || out_free;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_rep_o   = out_rep_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    run_valid_d = run_valid_q;
    run_word_d  = run_word_q;
    run_cnt_d   = run_cnt_q;
    res_cnt_d   = res_cnt_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    out_rep_d   = out_rep_q;
    out_last_d  = out_last_q;
    if (push_valid_i && !drop_q) begin
      if (!run_valid_q) begin
        run_valid_d = 1'b1;
        run_word_d  = push_word_i;
        run_cnt_d   = 6'd1;
      end else if (match) begin
        run_cnt_d = run_cnt_q + 6'd1;
      end else begin
        out_valid_d = 1'b1;
        out_word_d  = run_word_q;
        out_rep_d   = run_cnt_q;
        out_last_d  = final_res;
        res_cnt_d   = res_cnt_q + 4'd1;
        if (final_res) begin
          drop_d      = 1'b1;
          run_valid_d = 1'b0;
        end else begin
          run_word_d = push_word_i;
          run_cnt_d  = 6'd1;
        end
      end
    end
    if (flush_i && flush_ok_o) begin
      if (run_valid_q) begin
        out_valid_d = 1'b1;
        out_word_d  = run_word_q;
        out_rep_d   = run_cnt_q;
        out_last_d  = 1'b1;
        run_valid_d = 1'b0;
      end
      res_cnt_d = 4'h0;
      drop_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    run_word_q <= run_word_d;
    run_cnt_q  <= run_cnt_d;
    out_word_q <= out_word_d;
    out_rep_q  <= out_rep_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      res_cnt_q   <= 4'h0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      run_valid_q <= run_valid_d;
      res_cnt_q   <= res_cnt_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/uf2bf_checker.sv]
// ----------------------------------------------------------------------------
// UF2 block framer checker
// Port-level assertions on the framer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module uf2bf_checker import uf2bf_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [31:0]           out_word_i,
  input logic [5:0]            out_rep_i,
  input logic                  out_last_i,
  input logic                  psel_i,
  input logic                  penable_i,
  input logic                  pwrite_i,
  input logic [APB_ADDR_W-1:0] paddr_i,
  input logic [31:0]           pwdata_i,
  input logic [31:0]           prdata_i
);

  logic in_fire;
  logic family_wr;

  assign in_fire   = in_valid_i && in_ready_i;
  assign family_wr = psel_i && penable_i && pwrite_i &&
                     (paddr_i[3:2] == REG_FAMILY_ID);

  // A stalled result holds its word, count and last flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i) &&
                                    $stable(out_rep_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // Bytes are processed one at a time, so input is closed right after a byte.
  a_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("input taken in back-to-back cycles");

  // Every result carries a nonzero repeat count.
  a_rep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_rep_i != 6'd0)
    else $error("result with zero repeat count");

  // A family id write reads back on the next cycle.
  a_family_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    family_wr |=> (paddr_i[3:2] != REG_FAMILY_ID) || (prdata_i == $past(pwdata_i)))
    else $error("family id readback mismatch");

endmodule

bind uf2_block_framer uf2bf_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_in.valid),
  .in_ready_i  (byte_in.ready),
  .out_valid_i (word_out.valid),
  .out_ready_i (word_out.ready),
  .out_word_i  (word_out.word),
  .out_rep_i   (word_out.repeat_res),
  .out_last_i  (word_out.run_last),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

`default_nettype wire

[test/tb_uf2_block_framer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UF2 block framer testbench
// Feeds firmware images byte by byte and checks every file word against an
// internal predictor of the framing, the CRC and the run merging. Registers
// are changed over APB between phases while the framer is idle, and both
// handshakes idle and stall at random, including one long output stall.
// ----------------------------------------------------------------------------

module tb_uf2_block_framer;
  import uf2bf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_WAIT  = 80;
  localparam int unsigned LONG_HOLD    = 500;

  typedef struct packed {
    logic [31:0] word;
    logic [5:0]  rep;
    logic        run_last;
  } file_word_t;

  class framer_scoreboard;
    logic [15:0] total_blocks;
    logic [31:0] base_address;
    logic [31:0] family_id;
    logic        crc_first;
    int unsigned offset;
    logic [15:0] block_idx;
    logic [23:0] partial;
    logic [31:0] crc;
    file_word_t  step_words[$];
    file_word_t  expected_words[$];
    int unsigned mismatches;

    function new();
      total_blocks = TOTAL_RESET;
      base_address = BASE_RESET;
      family_id    = FAMILY_RESET;
      crc_first    = CRC_EN_RESET;
      offset       = 0;
      block_idx    = '0;
      partial      = '0;
      crc          = CRC_INIT;
      mismatches   = 0;
    endfunction

    function void write_reg(uf2bf_reg_e r, logic [31:0] v);
      case (r)
        REG_TOTAL_BLOCKS: total_blocks = v[15:0];
        REG_BASE_ADDRESS: base_address = v;
        REG_FAMILY_ID:    family_id = v;
        default:          crc_first = v[0];
      endcase
    endfunction

    // Appends count copies of a file word, merging into the open run.
    function void emit(logic [31:0] w, int unsigned count);
      file_word_t  fw;
      int unsigned take;
      int unsigned tail;
      while (count > 0) begin
        tail = step_words.size() - 1;
        if (step_words.size() > 0 && step_words[tail].word == w &&
            step_words[tail].rep < MAX_RUN) begin
          take = MAX_RUN - step_words[tail].rep;
          if (count < take) take = count;
          step_words[tail].rep = step_words[tail].rep + 6'(take);
        end else begin
          take = (count < MAX_RUN) ? count : MAX_RUN;
          fw.word = w;
          fw.rep = 6'(take);
          fw.run_last = 1'b0;
          step_words.push_back(fw);
        end
        count -= take;
      end
    endfunction

    function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
      c = c ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) begin
        c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      end
      return c;
    endfunction

    function void absorb(logic [7:0] b);
      bit crc_on;
      crc_on = (block_idx == 16'h0) && crc_first;
      if (crc_on && offset >= CRC_SPAN) begin
        if (offset == OFFSET_LAST) emit(crc, 1);
      end else begin
        if (crc_on) crc = crc_update(crc, b);
        if (offset % 4 == 3) begin
          emit({b, partial}, 1);
          partial = '0;
        end else begin
          partial = partial | (24'(b) << (8 * (offset % 4)));
        end
      end
      offset++;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      step_words.delete();
      if (offset == 0) begin
        emit(MAGIC_START0, 1);
        emit(MAGIC_START1, 1);
        emit(HDR_FLAGS, 1);
        emit(base_address + {8'h0, block_idx, 8'h0}, 1);
        emit(BLOCK_SIZE_WORD, 1);
        emit({16'h0, block_idx}, 1);
        emit({16'h0, total_blocks}, 1);
        emit(family_id, 1);
      end
      absorb(b);
      if (last) begin
        while (offset < BLOCK_BYTES) absorb(PAD_BYTE);
      end
      if (offset >= BLOCK_BYTES) begin
        emit(32'h0, TAIL_ZEROS);
        emit(TRAILER_MAGIC, 1);
        offset = 0;
        partial = '0;
        block_idx = block_idx + 16'h1;
      end
      if (last) begin
        block_idx = '0;
        crc = CRC_INIT;
      end
      while (step_words.size() > MAX_RES) void'(step_words.pop_back());
      if (step_words.size() > 0) step_words[step_words.size() - 1].run_last = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    function void check_word(logic [31:0] w, logic [5:0] rep, logic last);
      file_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word %h repeat %0d last %b", $time, w, rep, last);
        return;
      end
      want = expected_words.pop_front();
      if (want.word != w || want.rep != rep || want.run_last != last) begin
        mismatches++;
        $display("%0t: expected word %h repeat %0d last %b, got word %h repeat %0d last %b",
                 $time, want.word, want.rep, want.run_last, w, rep, last);
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  bit                hold_armed;
  int unsigned       hold_left;
  int unsigned       cycle_cnt;
  framer_scoreboard  sb;

  uf2bf_in_if  byte_if ();
  uf2bf_out_if word_if ();

  uf2_block_framer i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .byte_in  (byte_if),
    .word_out (word_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver draws ready at each falling edge and takes words at the rising edge.
  initial begin
    word_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_armed) begin
        hold_left = LONG_HOLD;
        hold_armed = 1'b0;
      end
      if (hold_left > 0) begin
        word_if.ready = 1'b0;
        hold_left--;
      end else begin
        word_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (word_if.valid && word_if.ready)
        sb.check_word(word_if.word, word_if.repeat_res, word_if.run_last);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk);
    end
    byte_if.valid = 1'b1;
    byte_if.data_byte = b;
    byte_if.end_of_image = last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    sb.note_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_image(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic wait_drained();
    byte_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic apb_write(uf2bf_reg_e r, logic [31:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = APB_ADDR_W'({r, 2'b00});
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(r, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic random_config();
    apb_write(REG_TOTAL_BLOCKS, 32'($urandom_range(65535, 1)));
    apb_write(REG_BASE_ADDRESS, $urandom);
    apb_write(REG_FAMILY_ID, $urandom);
    apb_write(REG_CRC_FIRST, 32'($urandom_range(3) != 0));
  endtask

  // Mostly complete images of random length, with some loose bytes mixed in.
  task automatic run_phase(int unsigned budget);
    int unsigned count;
    int unsigned pick;
    int unsigned len;
    count = 0;
    while (count < budget) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
        count++;
      end else begin
        len = (pick < 85) ? $urandom_range(16, 1) : $urandom_range(64, 17);
        send_image(len);
        count += len;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.end_of_image = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed = 1'b0;
    cycle_cnt = 0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b1);
    wait_drained();

    apb_write(REG_CRC_FIRST, 32'h0);
    apb_write(REG_TOTAL_BLOCKS, 32'h0000ffff);
    apb_write(REG_BASE_ADDRESS, 32'hffffffff);
    apb_write(REG_FAMILY_ID, 32'hffffffff);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    wait_drained();

    // The CRC is switched on in the middle of block zero.
    apb_write(REG_TOTAL_BLOCKS, 32'h1);
    apb_write(REG_BASE_ADDRESS, 32'h0);
    apb_write(REG_FAMILY_ID, 32'h0);
    for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();
    apb_write(REG_CRC_FIRST, 32'h1);
    send_byte(8'h3c, 1'b1);
    wait_drained();

    random_config();
    send_idle_pct = 8;
    recv_idle_pct = 60;
    run_phase(10);
    wait_drained();

    random_config();
    send_idle_pct = 60;
    recv_idle_pct = 8;
    run_phase(10);
    wait_drained();

    // A multi-block image whose second block address wraps past zero.
    apb_write(REG_TOTAL_BLOCKS, 32'($urandom_range(65535, 1)));
    apb_write(REG_BASE_ADDRESS, 32'hffffff00 | 32'($urandom_range(255)));
    apb_write(REG_FAMILY_ID, $urandom);
    apb_write(REG_CRC_FIRST, 32'h1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed = 1'b1;
    send_image($urandom_range(260, 257));
    run_phase(4);

    byte_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(negedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected words never arrived", $time, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
